/* rtl/length_prefixed_packet_ring_assert.svh */
// Assertion macros for the length-prefixed packet ring.
// Included by the top level; needs nothing else.
`ifndef LENGTH_PREFIXED_PACKET_RING_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_RING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPPR_ASSERT_NOW(lbl, clk, rst, cond, res) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (res)) \
      else $error("length_prefixed_packet_ring: check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPPR_ASSERT_NEXT(lbl, clk, rst, cond, res) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
      else $error("length_prefixed_packet_ring: check failed");

`endif

/* rtl/lppr_pkg.sv */
// Shared types and constants for the length-prefixed packet ring.
// Used by the controller, the datapath and the top level; depends on nothing.
package lppr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 13;
   localparam int STS_W  = 2;

   // Saturation point of the pending packet length.
   localparam logic [LEN_W-1:0] LEN_MAX   = 13'h1FFF;
   localparam logic [LEN_W-1:0] MAX_RESET = 13'd1024;

   localparam logic [STS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STATUS_COMMITTED = 2'd1;
   localparam logic [STS_W-1:0] STATUS_DROPPED   = 2'd2;
   localparam logic [STS_W-1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HDR_WR,
      ST_HDR_CAP,
      ST_HDR_END,
      ST_DATA_CAP
   } state_type;

   typedef enum logic [2:0] {
      RSP_OK,
      RSP_COMMIT,
      RSP_DROP,
      RSP_EMPTY,
      RSP_BYTE
   } rsp_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         item_load;
      logic         push_step;
      logic         pkt_drop;
      logic         hdr_write;
      logic         commit;
      logic         cnt_inc;
      logic         pop_rd;
      logic         hdr_cap;
      logic         hdr_done;
      logic         data_cap;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_pop;
      logic eop;
      logic push_fits;
      logic in_packet;
      logic ring_empty;
      logic cnt_last;
      logic len_zero;
      logic out_free;
   } sts_type;

endpackage

/* rtl/lppr_ctrl.sv */
// Controller state machine of the length-prefixed packet ring.
// Uses lppr_pkg for the state, command and status types.
module lppr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lppr_pkg::sts_type sts,
   output lppr_pkg::cmd_type cmd
);

   lppr_pkg::state_type state_ff;
   lppr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lppr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = lppr_pkg::RSP_OK;
      state_in     = state_ff;
      req_stall    = (state_ff != lppr_pkg::ST_IDLE);
      case (state_ff)
         lppr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = lppr_pkg::ST_EXEC;
            end
         end
         lppr_pkg::ST_EXEC: begin
            if (!sts.is_pop) begin
               if (sts.eop && sts.push_fits) begin
                  cmd.push_step = 1'b1;
                  state_in      = lppr_pkg::ST_HDR_WR;
               end else if (sts.out_free) begin
                  cmd.push_step = 1'b1;
                  cmd.pkt_drop  = sts.eop;
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_kind  = sts.eop ? lppr_pkg::RSP_DROP : lppr_pkg::RSP_OK;
                  state_in      = lppr_pkg::ST_IDLE;
               end
            end else if (sts.in_packet) begin
               cmd.pop_rd = 1'b1;
               state_in   = lppr_pkg::ST_DATA_CAP;
            end else if (sts.ring_empty) begin
               if (sts.out_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = lppr_pkg::RSP_EMPTY;
                  state_in     = lppr_pkg::ST_IDLE;
               end
            end else begin
               cmd.pop_rd = 1'b1;
               state_in   = lppr_pkg::ST_HDR_CAP;
            end
         end
         lppr_pkg::ST_HDR_WR: begin
            if (!sts.cnt_last) begin
               cmd.hdr_write = 1'b1;
               cmd.cnt_inc   = 1'b1;
            end else if (sts.out_free) begin
               cmd.hdr_write = 1'b1;
               cmd.commit    = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_kind  = lppr_pkg::RSP_COMMIT;
               state_in      = lppr_pkg::ST_IDLE;
            end
         end
         lppr_pkg::ST_HDR_CAP: begin
            cmd.hdr_cap = 1'b1;
            if (sts.cnt_last) begin
               state_in = lppr_pkg::ST_HDR_END;
            end else begin
               cmd.cnt_inc = 1'b1;
               cmd.pop_rd  = 1'b1;
            end
         end
         lppr_pkg::ST_HDR_END: begin
            cmd.hdr_done = 1'b1;
            if (!sts.len_zero) begin
               cmd.pop_rd = 1'b1;
               state_in   = lppr_pkg::ST_DATA_CAP;
            end else if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = lppr_pkg::RSP_OK;
               state_in     = lppr_pkg::ST_IDLE;
            end
         end
         lppr_pkg::ST_DATA_CAP: begin
            if (sts.out_free) begin
               cmd.data_cap = 1'b1;
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = lppr_pkg::RSP_BYTE;
               state_in     = lppr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lppr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/lppr_dp.sv */
// Datapath of the length-prefixed packet ring: byte memory, pointers,
// packet bookkeeping, length register and result register. Uses lppr_pkg.
module lppr_dp #(
   parameter int RING_BYTES   = 4096,
   parameter int HEADER_BYTES = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_action,
   input  logic [lppr_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                           req_end_of_packet,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [lppr_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic                           rsp_read_last,
   output logic                           rsp_read_valid,
   output logic [lppr_pkg::STS_W-1:0]     rsp_status,
   input  logic                           csr_write_enable,
   input  logic [lppr_pkg::LEN_W-1:0]     csr_write_data,
   input  lppr_pkg::cmd_type              cmd,
   output lppr_pkg::sts_type              sts
);

   localparam int AW  = $clog2(RING_BYTES);
   localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int NW  = ((AW > lppr_pkg::LEN_W) ? AW : lppr_pkg::LEN_W) + 2;
   localparam logic [lppr_pkg::LEN_W-1:0] LEN_CAP =
      (HEADER_BYTES >= 2) ? lppr_pkg::LEN_MAX : 13'h00FF;

   function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [AW:0] n);
      logic [AW:0] s;
      s = {1'b0, p} + n;
      if (s >= (AW+1)'(RING_BYTES)) begin
         s = s - (AW+1)'(RING_BYTES);
      end
      return s[AW-1:0];
   endfunction

   logic [lppr_pkg::BYTE_W-1:0] ring_mem [0:RING_BYTES-1];
   logic [lppr_pkg::BYTE_W-1:0] mem_q_ff;

   logic [AW-1:0]                rp_ff, rp_in;
   logic [AW-1:0]                cp_ff, cp_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [lppr_pkg::LEN_W-1:0]   pend_ff, pend_in;
   logic                         ovf_ff, ovf_in;
   logic [lppr_pkg::LEN_W-1:0]   remain_ff, remain_in;
   logic                         in_pkt_ff, in_pkt_in;
   logic [lppr_pkg::LEN_W-1:0]   max_len_ff, max_len_in;
   logic [lppr_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [HCW-1:0]               cnt_ff, cnt_in;
   logic                         item_action_ff;
   logic [lppr_pkg::BYTE_W-1:0]  item_byte_ff;
   logic                         item_eop_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lppr_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                         rsp_last_ff;
   logic                         rsp_rvalid_ff;
   logic [lppr_pkg::STS_W-1:0]   rsp_status_ff;

   logic [AW-1:0]                committed;
   logic [lppr_pkg::LEN_W-1:0]   newlen;
   logic [NW-1:0]                need;
   logic                         fits;
   logic [AW-1:0]                hdr_addr;
   logic [lppr_pkg::BYTE_W-1:0]  hdr_byte;
   logic                         mem_we;
   logic [AW-1:0]                mem_wa;
   logic [lppr_pkg::BYTE_W-1:0]  mem_wd;

   // Space check for the byte being pushed, header byte selection and the memory write mux.
   always_comb begin
      committed = (cp_ff >= rp_ff) ? (cp_ff - rp_ff)
                : AW'({1'b0, cp_ff} + (AW+1)'(RING_BYTES) - {1'b0, rp_ff});
      newlen    = (pend_ff == lppr_pkg::LEN_MAX) ? lppr_pkg::LEN_MAX
                : pend_ff + 13'd1;
      need      = NW'(committed) + NW'(HEADER_BYTES) + NW'(newlen);
      fits      = !ovf_ff && !(need > NW'(RING_BYTES - 1))
                && !(newlen > max_len_ff) && !(newlen > LEN_CAP);
      hdr_addr  = ptr_add(cp_ff, (AW+1)'(cnt_ff));
      if (cnt_ff == '0) begin
         hdr_byte = pend_ff[7:0];
      end else if (cnt_ff == HCW'(1)) begin
         hdr_byte = {3'b000, pend_ff[12:8]};
      end else begin
         hdr_byte = '0;
      end
      mem_we = 1'b0;
      mem_wa = wp_ff;
      mem_wd = item_byte_ff;
      if (cmd.push_step && fits) begin
         mem_we = 1'b1;
      end else if (cmd.hdr_write) begin
         mem_we = 1'b1;
         mem_wa = hdr_addr;
         mem_wd = hdr_byte;
      end
   end

   always_comb begin
      rp_in      = rp_ff;
      cp_in      = cp_ff;
      wp_in      = wp_ff;
      pend_in    = pend_ff;
      ovf_in     = ovf_ff;
      remain_in  = remain_ff;
      in_pkt_in  = in_pkt_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      max_len_in = csr_write_enable ? csr_write_data : max_len_ff;

      if (cmd.item_load) begin
         len_in = '0;
         cnt_in = '0;
      end
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + HCW'(1);
      end
      if (cmd.push_step) begin
         pend_in = newlen;
         ovf_in  = !fits;
         if (fits) begin
            wp_in = ptr_add(wp_ff, (AW+1)'(1));
         end
      end
      // A dropped packet rewinds to a fresh header slot at the commit point.
      if (cmd.pkt_drop) begin
         pend_in = '0;
         ovf_in  = 1'b0;
         wp_in   = ptr_add(cp_ff, (AW+1)'(HEADER_BYTES));
      end
      if (cmd.commit) begin
         cp_in   = wp_ff;
         wp_in   = ptr_add(wp_ff, (AW+1)'(HEADER_BYTES));
         pend_in = '0;
         ovf_in  = 1'b0;
      end
      if (cmd.pop_rd) begin
         rp_in = ptr_add(rp_ff, (AW+1)'(1));
      end
      // Only the low 13 bits of the length header matter.
      if (cmd.hdr_cap) begin
         if (cnt_ff == '0) begin
            len_in[7:0] = mem_q_ff;
         end else if (cnt_ff == HCW'(1)) begin
            len_in[12:8] = mem_q_ff[4:0];
         end
      end
      if (cmd.hdr_done) begin
         remain_in = len_ff;
         in_pkt_in = (len_ff != '0);
      end
      if (cmd.data_cap) begin
         remain_in = remain_ff - 13'd1;
         in_pkt_in = (remain_ff != 13'd1);
      end
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wa] <= mem_wd;
      end
      if (cmd.pop_rd) begin
         mem_q_ff <= ring_mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         cp_ff        <= '0;
         wp_ff        <= AW'(HEADER_BYTES);
         pend_ff      <= '0;
         ovf_ff       <= 1'b0;
         remain_ff    <= '0;
         in_pkt_ff    <= 1'b0;
         max_len_ff   <= lppr_pkg::MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         cp_ff        <= cp_in;
         wp_ff        <= wp_in;
         pend_ff      <= pend_in;
         ovf_ff       <= ovf_in;
         remain_ff    <= remain_in;
         in_pkt_ff    <= in_pkt_in;
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      cnt_ff <= cnt_in;
      if (cmd.item_load) begin
         item_action_ff <= req_action;
         item_byte_ff   <= req_data_byte;
         item_eop_ff    <= req_end_of_packet;
      end
      if (cmd.rsp_load) begin
         rsp_byte_ff   <= (cmd.rsp_kind == lppr_pkg::RSP_BYTE) ? mem_q_ff : '0;
         rsp_last_ff   <= (cmd.rsp_kind == lppr_pkg::RSP_BYTE) && (remain_ff == 13'd1);
         rsp_rvalid_ff <= (cmd.rsp_kind == lppr_pkg::RSP_BYTE);
         case (cmd.rsp_kind)
            lppr_pkg::RSP_OK:     rsp_status_ff <= lppr_pkg::STATUS_OK;
            lppr_pkg::RSP_COMMIT: rsp_status_ff <= lppr_pkg::STATUS_COMMITTED;
            lppr_pkg::RSP_DROP:   rsp_status_ff <= lppr_pkg::STATUS_DROPPED;
            lppr_pkg::RSP_EMPTY:  rsp_status_ff <= lppr_pkg::STATUS_EMPTY;
            lppr_pkg::RSP_BYTE:   rsp_status_ff <= lppr_pkg::STATUS_OK;
            default:              rsp_status_ff <= lppr_pkg::STATUS_OK;
         endcase
      end
   end

   assign sts.is_pop     = item_action_ff;
   assign sts.eop        = item_eop_ff;
   assign sts.push_fits  = fits;
   assign sts.in_packet  = in_pkt_ff;
   assign sts.ring_empty = (rp_ff == cp_ff);
   assign sts.cnt_last   = (cnt_ff == HCW'(HEADER_BYTES - 1));
   assign sts.len_zero   = (len_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_read_last  = rsp_last_ff;
   assign rsp_read_valid = rsp_rvalid_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

/* rtl/length_prefixed_packet_ring.sv */
// Top level of the length-prefixed packet ring.
// Depends on lppr_pkg, lppr_ctrl, lppr_dp and length_prefixed_packet_ring_assert.svh.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  action, data_byte, end_of_packet
//   rsp      out        rsp_valid/rsp_stall  read_byte, read_last, read_valid, status
//   csr      in         csr_write_enable     csr_write_data (max_packet_len)
//
// One item is worked at a time. A last byte that commits also writes the header, which goes
// through the single memory write port one byte a cycle, the last byte once the result register
// is free. A pop inside a packet uses the registered memory read; the first pop of a packet
// also does the header reads. Reset is synchronous and clears the state machine, pointers and
// packet bookkeeping and sets max_packet_len to 1024; the byte memory needs no clearing pass.
// A stalled result holds the block only when the next result is due.

`include "length_prefixed_packet_ring_assert.svh"

module length_prefixed_packet_ring #(
   parameter int RING_BYTES   = 4096,
   parameter int HEADER_BYTES = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [lppr_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                        req_end_of_packet,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lppr_pkg::BYTE_W-1:0] rsp_read_byte,
   output logic                        rsp_read_last,
   output logic                        rsp_read_valid,
   output logic [lppr_pkg::STS_W-1:0]  rsp_status,
   input  logic                        csr_write_enable,
   input  logic [lppr_pkg::LEN_W-1:0]  csr_write_data
);

   // The controller steers the datapath through command strobes and sees only
   // the datapath's status flags in return.
   lppr_pkg::cmd_type ctrl_cmd;
   lppr_pkg::sts_type dp_sts;

   lppr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (ctrl_cmd)
   );

   // The datapath holds the ring memory, pointers, packet length bookkeeping,
   // the max_packet_len register and the result register that parts the
   // result channel from the work in progress.
   lppr_dp #(
      .RING_BYTES   (RING_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_read_last     (rsp_read_last),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (ctrl_cmd),
      .sts               (dp_sts)
   );

   // An accepted transfer keeps the input side busy in the following cycle.
   `LPPR_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_valid && !req_stall, req_stall)
   // A result without a payload byte never marks the end of a packet.
   `LPPR_ASSERT_NOW(a_last_needs_byte, clock, reset, rsp_valid && !rsp_read_valid, !rsp_read_last)
   // A result that carries a payload byte always reports the ok status.
   `LPPR_ASSERT_NOW(a_byte_status_ok, clock, reset, rsp_valid && rsp_read_valid, rsp_status == lppr_pkg::STATUS_OK)

endmodule
